>>> hdl/fdsdc_pkg.sv
// shared types, codes, constants and glyph helpers for the segment display controller
package fdsdc_pkg;

	// operation codes
	localparam logic [3:0] OP_RAW_DIGIT  = 4'd0;
	localparam logic [3:0] OP_HEX_DIGIT  = 4'd1;
	localparam logic [3:0] OP_RAW_ALL    = 4'd2;
	localparam logic [3:0] OP_HEX_ALL    = 4'd3;
	localparam logic [3:0] OP_LITERAL    = 4'd4;
	localparam logic [3:0] OP_BRIGHTNESS = 4'd5;
	localparam logic [3:0] OP_OFF        = 4'd6;
	localparam logic [3:0] OP_CLEAR      = 4'd7;
	localparam logic [3:0] OP_COLON      = 4'd8;

	// bus command bytes
	localparam logic [7:0] CMD_DATA_AUTO  = 8'h40;
	localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
	localparam logic [7:0] CMD_ADDR       = 8'hC0;
	localparam logic [7:0] CTRL_OFF       = 8'h80;
	localparam logic [7:0] CTRL_ON_BASE   = 8'h88;
	localparam logic [7:0] CTRL_RESET     = 8'h8F;
	localparam logic [7:0] COLON_BIT      = 8'h80;

	// decimal literal limit and reciprocal of ten (exact for values below 43690)
	localparam logic [15:0] DEC_MAX     = 16'd9999;
	localparam logic [15:0] RECIP_TEN   = 16'd52429;
	localparam int          RECIP_SHIFT = 19;

	// frame byte indexes
	localparam logic [2:0] FIXED_LAST = 3'd3;
	localparam logic [2:0] AUTO_LAST  = 3'd6;

	localparam logic [7:0] SEG_FONT [16] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
	};

	typedef enum logic [0:0] {
		FE_IDLE,
		FE_DEC
	} fe_state_t;

	// input transaction
	typedef struct packed {
		logic [3:0]  operation;
		logic [2:0]  position;
		logic [7:0]  digit_value;
		logic [15:0] literal_value;
		logic        radix_hex;
		logic [7:0]  brightness_percent;
		logic        colon_on;
		logic [7:0]  lane_0;
		logic [7:0]  lane_1;
		logic [7:0]  lane_2;
		logic [7:0]  lane_3;
	} cmd_t;

	// output transaction
	typedef struct packed {
		logic [7:0] bus_byte;
		logic       start_before;
		logic       stop_after;
		logic       frame_last;
	} bus_t;

	// snapshot of one frame to send
	typedef struct packed {
		logic            fixed;
		logic [1:0]      pos;
		logic [3:0][7:0] seg;
		logic [7:0]      ctrl;
	} frame_t;

	// hex value to glyph, blank above fifteen
	function automatic logic [7:0] hex_glyph(input logic [7:0] v);
		logic [7:0] g;
		begin
			if (v > 8'd15) begin
				g = 8'h00;
			end else begin
				g = SEG_FONT[v[3:0]];
			end
			return g;
		end
	endfunction

	// brightness level floor((7p+50)/100), saturating at seven
	function automatic logic [2:0] bright_level(input logic [7:0] p);
		logic [2:0] l;
		begin
			if (p >= 8'd93) begin
				l = 3'd7;
			end else if (p >= 8'd79) begin
				l = 3'd6;
			end else if (p >= 8'd65) begin
				l = 3'd5;
			end else if (p >= 8'd50) begin
				l = 3'd4;
			end else if (p >= 8'd36) begin
				l = 3'd3;
			end else if (p >= 8'd22) begin
				l = 3'd2;
			end else if (p >= 8'd8) begin
				l = 3'd1;
			end else begin
				l = 3'd0;
			end
			return l;
		end
	endfunction

endpackage

>>> hdl/fdsdc_fifo.sv
// two-entry frame queue between command front end and byte sequencer
module fdsdc_fifo
	import fdsdc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  frame_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output frame_t rd_data,
	output logic   empty
);

	frame_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> hdl/fdsdc_front.sv
// command front end: decodes commands, updates display state, queues frames
module fdsdc_front
	import fdsdc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	output logic   cmd_ready,
	input  cmd_t   cmd,
	output logic   push,
	output frame_t push_frame,
	input  logic   queue_full
);

	fe_state_t       state_q, state_d;
	logic [3:0][7:0] seg_q, seg_d;
	logic [7:0]      ctrl_q, ctrl_d;
	logic [1:0]      cnt_q, cnt_d;
	logic [13:0]     val_q, val_d;
	logic            accept;
	logic            pos_ok;
	logic [1:0]      pos;
	logic [29:0]     prod;
	logic [9:0]      quot;
	logic [13:0]     quot_x10;
	logic [3:0]      dec_digit;
	logic            dec_step;

	assign cmd_ready = (state_q == FE_IDLE) && !queue_full;
	assign accept    = cmd_valid && cmd_ready;
	assign pos_ok    = (cmd.position <= 3'd3);
	assign pos       = cmd.position[1:0];

	// one digit per cycle by reciprocal multiply; a full queue holds the last
	assign prod      = {16'd0, val_q} * {14'd0, RECIP_TEN};
	assign quot      = prod[RECIP_SHIFT+9:RECIP_SHIFT];
	assign quot_x10  = {1'b0, quot, 3'd0} + {3'd0, quot, 1'b0};
	assign dec_digit = 4'(val_q - quot_x10);
	assign dec_step  = (state_q == FE_DEC) && ((cnt_q != 2'd3) || !queue_full);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FE_IDLE: begin
				if (accept && (cmd.operation == OP_LITERAL) && !cmd.radix_hex
						&& (cmd.literal_value <= DEC_MAX)) begin
					state_d = FE_DEC;
				end
			end
			FE_DEC: begin
				if (dec_step && (cnt_q == 2'd3)) begin
					state_d = FE_IDLE;
				end
			end
			default: begin
				state_d = FE_IDLE;
			end
		endcase
	end

	// display state update and frame push
	always_comb begin
		seg_d              = seg_q;
		ctrl_d             = ctrl_q;
		cnt_d              = cnt_q;
		val_d              = val_q;
		push               = 1'b0;
		push_frame.fixed   = 1'b0;
		push_frame.pos     = pos;
		case (state_q)
			FE_IDLE: begin
				if (accept) begin
					case (cmd.operation)
						OP_RAW_DIGIT: begin
							if (pos_ok) begin
								seg_d[pos]       = cmd.digit_value;
								push             = 1'b1;
								push_frame.fixed = 1'b1;
							end
						end
						OP_HEX_DIGIT: begin
							if (pos_ok) begin
								seg_d[pos]       = hex_glyph(cmd.digit_value);
								push             = 1'b1;
								push_frame.fixed = 1'b1;
							end
						end
						OP_RAW_ALL: begin
							seg_d = {cmd.lane_3, cmd.lane_2, cmd.lane_1, cmd.lane_0};
							push  = 1'b1;
						end
						OP_HEX_ALL: begin
							seg_d[0] = hex_glyph(cmd.lane_0);
							seg_d[1] = hex_glyph(cmd.lane_1);
							seg_d[2] = hex_glyph(cmd.lane_2);
							seg_d[3] = hex_glyph(cmd.lane_3);
							push     = 1'b1;
						end
						OP_LITERAL: begin
							if (cmd.radix_hex) begin
								seg_d[0] = SEG_FONT[cmd.literal_value[15:12]];
								seg_d[1] = SEG_FONT[cmd.literal_value[11:8]];
								seg_d[2] = SEG_FONT[cmd.literal_value[7:4]];
								seg_d[3] = SEG_FONT[cmd.literal_value[3:0]];
								push     = 1'b1;
							end else if (cmd.literal_value <= DEC_MAX) begin
								val_d = cmd.literal_value[13:0];
								cnt_d = 2'd0;
							end
						end
						OP_BRIGHTNESS: begin
							ctrl_d = CTRL_ON_BASE | {5'd0, bright_level(cmd.brightness_percent)};
							push   = 1'b1;
						end
						OP_OFF: begin
							ctrl_d = CTRL_OFF;
							push   = 1'b1;
						end
						OP_CLEAR: begin
							seg_d = '0;
							push  = 1'b1;
						end
						OP_COLON: begin
							for (int i = 0; i < 4; i++) begin
								if (cmd.colon_on) begin
									seg_d[i] = seg_q[i] | COLON_BIT;
								end else begin
									seg_d[i] = seg_q[i] & ~COLON_BIT;
								end
							end
							push = 1'b1;
						end
						default: begin
							push = 1'b0;
						end
					endcase
				end
			end
			FE_DEC: begin
				// least significant digit lands in the last position first
				if (dec_step) begin
					seg_d[2'd3 - cnt_q] = SEG_FONT[dec_digit];
					val_d               = {4'd0, quot};
					cnt_d               = cnt_q + 2'd1;
					push                = (cnt_q == 2'd3);
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
		push_frame.seg  = seg_d;
		push_frame.ctrl = ctrl_d;
	end

	// control and display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			seg_q   <= '0;
			ctrl_q  <= CTRL_RESET;
			cnt_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			ctrl_q  <= ctrl_d;
			cnt_q   <= cnt_d;
		end
	end

	// working value of the decimal conversion
	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

>>> hdl/fdsdc_back.sv
// byte sequencer: walks queued frames and drives the output register
module fdsdc_back
	import fdsdc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   queue_empty,
	input  frame_t head,
	output logic   pop,
	output logic   bus_valid,
	input  logic   bus_ready,
	output bus_t   bus
);

	logic [2:0] byte_q;
	logic       out_valid_q;
	bus_t       out_q;
	bus_t       next_byte;
	logic       last_byte;
	logic       load;
	logic [1:0] seg_idx;

	assign load      = !queue_empty && (!out_valid_q || bus_ready);
	assign last_byte = head.fixed ? (byte_q == FIXED_LAST) : (byte_q == AUTO_LAST);
	assign pop       = load && last_byte;
	assign seg_idx   = 2'(byte_q - 3'd2);
	assign bus_valid = out_valid_q;
	assign bus       = out_q;

	// byte for the current position in the frame
	always_comb begin
		next_byte.bus_byte     = 8'h00;
		next_byte.start_before = 1'b0;
		next_byte.stop_after   = 1'b0;
		next_byte.frame_last   = 1'b0;
		if (head.fixed) begin
			case (byte_q)
				3'd0: begin
					next_byte.bus_byte     = CMD_DATA_FIXED;
					next_byte.start_before = 1'b1;
					next_byte.stop_after   = 1'b1;
				end
				3'd1: begin
					next_byte.bus_byte     = CMD_ADDR | {6'd0, head.pos};
					next_byte.start_before = 1'b1;
				end
				3'd2: begin
					next_byte.bus_byte   = head.seg[head.pos];
					next_byte.stop_after = 1'b1;
				end
				default: begin
					next_byte.bus_byte     = head.ctrl;
					next_byte.start_before = 1'b1;
					next_byte.stop_after   = 1'b1;
					next_byte.frame_last   = 1'b1;
				end
			endcase
		end else begin
			case (byte_q)
				3'd0: begin
					next_byte.bus_byte     = CMD_DATA_AUTO;
					next_byte.start_before = 1'b1;
					next_byte.stop_after   = 1'b1;
				end
				3'd1: begin
					next_byte.bus_byte     = CMD_ADDR;
					next_byte.start_before = 1'b1;
				end
				3'd2, 3'd3, 3'd4: begin
					next_byte.bus_byte = head.seg[seg_idx];
				end
				3'd5: begin
					next_byte.bus_byte   = head.seg[seg_idx];
					next_byte.stop_after = 1'b1;
				end
				default: begin
					next_byte.bus_byte     = head.ctrl;
					next_byte.start_before = 1'b1;
					next_byte.stop_after   = 1'b1;
					next_byte.frame_last   = 1'b1;
				end
			endcase
		end
	end

	// frame position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				byte_q      <= last_byte ? 3'd0 : byte_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (bus_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_byte;
		end
	end

endmodule

>>> hdl/four_digit_segment_display_ctrl.sv
// top level of the four-digit segment display controller
// path: a frame passes the frame queue and output register; a decimal literal first
// has its four digits extracted in the front end
// throughput: one bus byte per cycle while a frame waits and the receiver is ready;
// the sequencer paces commands; a two-frame queue lets them arrive while bytes go out
// reset: segments cleared, control byte 0x8F, queue and output register empty
module four_digit_segment_display_ctrl
	import fdsdc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic bus_valid,
	input  logic bus_ready,
	output bus_t bus
);

	logic   push;
	frame_t push_frame;
	logic   queue_full;
	logic   queue_empty;
	logic   pop;
	frame_t head;

	// command decode and display state
	fdsdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.push       (push),
		.push_frame (push_frame),
		.queue_full (queue_full)
	);

	// frame queue
	fdsdc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_frame),
		.full    (queue_full),
		.rd_en   (pop),
		.rd_data (head),
		.empty   (queue_empty)
	);

	// bus byte sequencing
	fdsdc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.bus_valid   (bus_valid),
		.bus_ready   (bus_ready),
		.bus         (bus)
	);

endmodule

>>> tb/testbench.sv
// self-checking testbench for the four-digit segment display controller
`timescale 1ns / 1ps

module testbench;
	import fdsdc_pkg::*;

	localparam int         CLK_HALF    = 4;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         DRAIN_WAIT  = 24;
	localparam int         PHASE_ITEMS = 132;
	localparam logic [3:0] OP_SPARE_TOP = 4'd15;

	// seven-segment glyphs for 0..F
	localparam logic [7:0] GLYPHS [16] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
	};

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_CTRL
	} row_kind_t;

	// one row of the directed table
	typedef struct {
		cmd_t      c;
		row_kind_t kind;
		logic [7:0] ctrl;
	} cmd_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	cmd_t        cmd = '0;
	logic        bus_valid;
	logic        bus_ready = 1'b0;
	bus_t        bus;

	// shadow of the display state
	logic [7:0]  seg_shadow [4];
	logic [7:0]  ctrl_shadow;

	bus_t        bus_expect_q [$];
	bus_t        want_byte;
	int          mismatches = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int unsigned cycle_count = 0;

	four_digit_segment_display_ctrl u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.bus_valid (bus_valid),
		.bus_ready (bus_ready),
		.bus       (bus)
	);

	// clock
	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [7:0] want,
		input logic [7:0] got);
		$display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
		mismatches++;
	endtask

	function automatic logic [7:0] glyph_of(input logic [7:0] v);
		if (v > 8'd15) begin
			return 8'h00;
		end
		return GLYPHS[v[3:0]];
	endfunction

	function automatic void queue_byte(input logic [7:0] b, input logic st,
		input logic sp, input logic last);
		bus_t e;
		e = {b, st, sp, last};
		bus_expect_q.push_back(e);
	endfunction

	// update the shadow state and queue the bus bytes one command causes
	function automatic int predict_bus_bytes(input cmd_t c);
		int frame_len;
		int i;
		int num;
		int level;
		frame_len = 7;
		case (c.operation)
			OP_RAW_DIGIT, OP_HEX_DIGIT: begin
				if (c.position > 3'd3) begin
					frame_len = 0;
				end else begin
					frame_len = 4;
					seg_shadow[c.position[1:0]] = (c.operation == OP_RAW_DIGIT) ?
						c.digit_value : glyph_of(c.digit_value);
				end
			end
			OP_RAW_ALL: begin
				seg_shadow[0] = c.lane_0;
				seg_shadow[1] = c.lane_1;
				seg_shadow[2] = c.lane_2;
				seg_shadow[3] = c.lane_3;
			end
			OP_HEX_ALL: begin
				seg_shadow[0] = glyph_of(c.lane_0);
				seg_shadow[1] = glyph_of(c.lane_1);
				seg_shadow[2] = glyph_of(c.lane_2);
				seg_shadow[3] = glyph_of(c.lane_3);
			end
			OP_LITERAL: begin
				num = c.literal_value;
				if (c.radix_hex) begin
					for (i = 3; i >= 0; i--) begin
						seg_shadow[i] = GLYPHS[num % 16];
						num = num / 16;
					end
				end else if (num > 9999) begin
					frame_len = 0;
				end else begin
					for (i = 3; i >= 0; i--) begin
						seg_shadow[i] = GLYPHS[num % 10];
						num = num / 10;
					end
				end
			end
			OP_BRIGHTNESS: begin
				if (c.brightness_percent == 8'd0) begin
					ctrl_shadow = CTRL_ON_BASE;
				end else if (c.brightness_percent >= 8'd100) begin
					ctrl_shadow = CTRL_RESET;
				end else begin
					level = (7 * int'(c.brightness_percent) + 50) / 100;
					ctrl_shadow = CTRL_ON_BASE | 8'(level);
				end
			end
			OP_OFF: begin
				ctrl_shadow = CTRL_OFF;
			end
			OP_CLEAR: begin
				for (i = 0; i < 4; i++) begin
					seg_shadow[i] = 8'h00;
				end
			end
			OP_COLON: begin
				for (i = 0; i < 4; i++) begin
					seg_shadow[i] = c.colon_on ? (seg_shadow[i] | COLON_BIT) :
						(seg_shadow[i] & ~COLON_BIT);
				end
			end
			default: begin
				frame_len = 0;
			end
		endcase

		// frame of bus bytes
		if (frame_len == 4) begin
			queue_byte(CMD_DATA_FIXED, 1'b1, 1'b1, 1'b0);
			queue_byte(CMD_ADDR | {6'd0, c.position[1:0]}, 1'b1, 1'b0, 1'b0);
			queue_byte(seg_shadow[c.position[1:0]], 1'b0, 1'b1, 1'b0);
			queue_byte(ctrl_shadow, 1'b1, 1'b1, 1'b1);
		end else if (frame_len == 7) begin
			queue_byte(CMD_DATA_AUTO, 1'b1, 1'b1, 1'b0);
			queue_byte(CMD_ADDR, 1'b1, 1'b0, 1'b0);
			queue_byte(seg_shadow[0], 1'b0, 1'b0, 1'b0);
			queue_byte(seg_shadow[1], 1'b0, 1'b0, 1'b0);
			queue_byte(seg_shadow[2], 1'b0, 1'b0, 1'b0);
			queue_byte(seg_shadow[3], 1'b0, 1'b1, 1'b0);
			queue_byte(ctrl_shadow, 1'b1, 1'b1, 1'b1);
		end
		return frame_len;
	endfunction

	// value drives digit, brightness and colon alike; lanes packed first lane high
	function automatic cmd_t cmd_of(input logic [3:0] op, input logic [2:0] pos,
		input logic [7:0] val, input logic [15:0] lit, input logic radix,
		input logic [31:0] lanes);
		cmd_t c;
		c.operation          = op;
		c.position           = pos;
		c.digit_value        = val;
		c.literal_value      = lit;
		c.radix_hex          = radix;
		c.brightness_percent = val;
		c.colon_on           = val[0];
		{c.lane_0, c.lane_1, c.lane_2, c.lane_3} = lanes;
		return c;
	endfunction

	// digit values leaning towards the hex range
	function automatic logic [7:0] pick_digit();
		if ($urandom_range(1, 0) == 0) begin
			return 8'($urandom_range(20, 0));
		end
		return 8'($urandom_range(255, 0));
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		if ($urandom_range(99, 0) < 6) begin
			c.operation = 4'($urandom_range(OP_SPARE_TOP, OP_COLON + 1));
		end else begin
			c.operation = 4'($urandom_range(OP_COLON, OP_RAW_DIGIT));
		end
		c.position    = ($urandom_range(99, 0) < 85) ? 3'($urandom_range(3, 0)) :
			3'($urandom_range(7, 4));
		c.digit_value = pick_digit();
		c.radix_hex   = 1'($urandom_range(1, 0));
		if (!c.radix_hex && $urandom_range(99, 0) < 85) begin
			c.literal_value = 16'($urandom_range(9999, 0));
		end else begin
			c.literal_value = 16'($urandom_range(65535, 0));
		end
		c.brightness_percent = ($urandom_range(99, 0) < 60) ? 8'($urandom_range(100, 0)) :
			8'($urandom_range(255, 0));
		c.colon_on = 1'($urandom_range(1, 0));
		c.lane_0   = pick_digit();
		c.lane_1   = pick_digit();
		c.lane_2   = pick_digit();
		c.lane_3   = pick_digit();
		return c;
	endfunction

	// one command transaction, with random idle cycles ahead of it
	task automatic send_cmd(input cmd_t c, input row_kind_t kind, input logic [7:0] ctrl,
		output int produced);
		bus_t tail;
		bit   lowered;
		lowered = 1'b0;
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			if (!lowered) begin
				cmd_valid <= 1'b0;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		produced = 0;
		if (kind != ROW_SILENT) begin
			produced = predict_bus_bytes(c);
		end
		// control byte typed in the table stands for the predicted one
		if (kind == ROW_CTRL && bus_expect_q.size() != 0) begin
			tail = bus_expect_q.pop_back();
			tail.bus_byte = ctrl;
			bus_expect_q.push_back(tail);
		end
	endtask

	// receiver stalls
	always @(posedge clk) begin
		bus_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
	end

	// compare each bus transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && bus_valid && bus_ready) begin
			if (bus_expect_q.size() == 0) begin
				report_mismatch("unexpected bus byte", 8'h00, bus.bus_byte);
			end else begin
				want_byte = bus_expect_q.pop_front();
				if (bus.bus_byte !== want_byte.bus_byte) begin
					report_mismatch("bus_byte", want_byte.bus_byte, bus.bus_byte);
				end
				if (bus.start_before !== want_byte.start_before) begin
					report_mismatch("start_before", 8'(want_byte.start_before),
						8'(bus.start_before));
				end
				if (bus.stop_after !== want_byte.stop_after) begin
					report_mismatch("stop_after", 8'(want_byte.stop_after),
						8'(bus.stop_after));
				end
				if (bus.frame_last !== want_byte.frame_last) begin
					report_mismatch("frame_last", 8'(want_byte.frame_last),
						8'(bus.frame_last));
				end
			end
		end
	end

	initial begin : stimulus
		cmd_row_t directed_rows [$];
		int       produced;
		int       busy_items;
		int       phase;
		int       k;

		for (k = 0; k < 4; k++) begin
			seg_shadow[k] = 8'h00;
		end
		ctrl_shadow = CTRL_RESET;

		// directed table: extremes, every operation, ignored commands
		directed_rows.push_back('{cmd_of(OP_CLEAR, 3'd0, 8'd0, 16'd0, 1'b0, 32'd0),
			ROW_CTRL, CTRL_RESET});
		directed_rows.push_back('{cmd_of(OP_RAW_DIGIT, 3'd0, 8'hFF, 16'd0, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_RAW_DIGIT, 3'd3, 8'h00, 16'hFFFF, 1'b1, '1),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_RAW_DIGIT, 3'd4, 8'hA5, 16'd0, 1'b0, 32'd0),
			ROW_SILENT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_HEX_DIGIT, 3'd7, 8'h03, 16'd0, 1'b0, 32'd0),
			ROW_SILENT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_HEX_DIGIT, 3'd1, 8'd15, 16'd0, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_HEX_DIGIT, 3'd2, 8'd16, 16'd0, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_HEX_DIGIT, 3'd2, 8'd255, 16'd0, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_RAW_ALL, 3'd0, 8'd0, 16'd0, 1'b0, 32'hFF00AA55),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_HEX_ALL, 3'd0, 8'd0, 16'd0, 1'b0, 32'h000F10FF),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_LITERAL, 3'd0, 8'd0, 16'd0, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_LITERAL, 3'd0, 8'd0, 16'd9999, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_LITERAL, 3'd0, 8'd0, 16'd10000, 1'b0, 32'd0),
			ROW_SILENT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_LITERAL, 3'd0, 8'd0, 16'hFFFF, 1'b0, 32'd0),
			ROW_SILENT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_LITERAL, 3'd0, 8'd0, 16'd1234, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_LITERAL, 3'd0, 8'd0, 16'hFFFF, 1'b1, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_LITERAL, 3'd0, 8'd0, 16'h0000, 1'b1, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_BRIGHTNESS, 3'd0, 8'd0, 16'd0, 1'b0, 32'd0),
			ROW_CTRL, CTRL_ON_BASE});
		directed_rows.push_back('{cmd_of(OP_BRIGHTNESS, 3'd0, 8'd50, 16'd0, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_BRIGHTNESS, 3'd0, 8'd100, 16'd0, 1'b0, 32'd0),
			ROW_CTRL, CTRL_RESET});
		directed_rows.push_back('{cmd_of(OP_BRIGHTNESS, 3'd0, 8'd255, 16'd0, 1'b0, 32'd0),
			ROW_CTRL, CTRL_RESET});
		directed_rows.push_back('{cmd_of(OP_OFF, 3'd0, 8'd0, 16'd0, 1'b0, 32'd0),
			ROW_CTRL, CTRL_OFF});
		directed_rows.push_back('{cmd_of(OP_COLON, 3'd0, 8'd1, 16'd0, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_COLON, 3'd0, 8'd0, 16'd0, 1'b0, 32'd0),
			ROW_PREDICT, 8'h00});
		directed_rows.push_back('{cmd_of(OP_SPARE_TOP, 3'd7, 8'hFF, 16'hFFFF, 1'b1, '1),
			ROW_SILENT, 8'h00});

		// reset
		tx_idle_pct  = 21;
		rx_stall_pct = 77;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			send_cmd(directed_rows[k].c, directed_rows[k].kind, directed_rows[k].ctrl,
				produced);
		end

		// random phases with different idling on each side
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct  = 21;
					rx_stall_pct = 77;
				end
				1: begin
					tx_idle_pct  = 77;
					rx_stall_pct = 21;
				end
				default: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
			endcase
			busy_items = 0;
			while (busy_items < PHASE_ITEMS) begin
				send_cmd(rand_cmd(), ROW_PREDICT, 8'h00, produced);
				busy_items++;
			end
		end
		cmd_valid <= 1'b0;

		// drain and watch for stray bytes
		while (bus_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
